// ===== sv/line_line_closest_points_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the line-line closest points block
// Concurrent assertion wrappers, empty when the code is synthesized.
// ----------------------------------------------------------------------------
`ifndef LINE_LINE_CLOSEST_POINTS_MACROS_SVH
`define LINE_LINE_CLOSEST_POINTS_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off while arst_n is low.
`define LLCP_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("llcp assertion failed");
// Next-cycle implication, sampled on clk, off while arst_n is low.
`define LLCP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("llcp assertion failed");
`else
`define LLCP_ASSERT_IMPL(lbl, ante, cons)
`define LLCP_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== sv/llcp_pkg.sv =====
// ----------------------------------------------------------------------------
// llcp_pkg
// Shared constants for the line-line closest points pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package llcp_pkg;

	localparam int COORD_BITS_DEF = 32;

	// Threshold register: Q0.16 fraction, compared against the denominator
	// after it is scaled from Q64.64 down to Q16.16.
	localparam int EPS_BITS = 16;
	localparam logic [EPS_BITS-1:0] EPS_RESET = 16'd1;
	localparam int EPS_SHIFT = 48;

	// Wide multipliers are built from partial products of this width.
	localparam int MUL_CHUNK = 32;
	localparam int MUL_LAT = 5;

	// Dot product slots.
	localparam int DOT_WV = 0;
	localparam int DOT_VU = 1;
	localparam int DOT_WU = 2;
	localparam int DOT_VV = 3;
	localparam int DOT_UU = 4;
	localparam int DOT_N = 5;

endpackage

// ===== sv/llcp_in_if.sv =====
// ----------------------------------------------------------------------------
// llcp_in_if
// Input channel: two points on each of the two lines.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface llcp_in_if import llcp_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) ();
	logic valid;
	logic ready;
	logic signed [COORD_BITS-1:0] a_start_x;
	logic signed [COORD_BITS-1:0] a_start_y;
	logic signed [COORD_BITS-1:0] a_start_z;
	logic signed [COORD_BITS-1:0] a_end_x;
	logic signed [COORD_BITS-1:0] a_end_y;
	logic signed [COORD_BITS-1:0] a_end_z;
	logic signed [COORD_BITS-1:0] b_start_x;
	logic signed [COORD_BITS-1:0] b_start_y;
	logic signed [COORD_BITS-1:0] b_start_z;
	logic signed [COORD_BITS-1:0] b_end_x;
	logic signed [COORD_BITS-1:0] b_end_y;
	logic signed [COORD_BITS-1:0] b_end_z;

	modport source (
		output valid, a_start_x, a_start_y, a_start_z, a_end_x, a_end_y, a_end_z,
		output b_start_x, b_start_y, b_start_z, b_end_x, b_end_y, b_end_z,
		input ready
	);
	modport sink (
		input valid, a_start_x, a_start_y, a_start_z, a_end_x, a_end_y, a_end_z,
		input b_start_x, b_start_y, b_start_z, b_end_x, b_end_y, b_end_z,
		output ready
	);
endinterface

// ===== sv/llcp_out_if.sv =====
// ----------------------------------------------------------------------------
// llcp_out_if
// Result channel: found flag and the two closest points.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface llcp_out_if import llcp_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) ();
	logic valid;
	logic ready;
	logic found;
	logic signed [COORD_BITS-1:0] near_a_x;
	logic signed [COORD_BITS-1:0] near_a_y;
	logic signed [COORD_BITS-1:0] near_a_z;
	logic signed [COORD_BITS-1:0] near_b_x;
	logic signed [COORD_BITS-1:0] near_b_y;
	logic signed [COORD_BITS-1:0] near_b_z;

	modport source (
		output valid, found, near_a_x, near_a_y, near_a_z, near_b_x, near_b_y, near_b_z,
		input ready
	);
	modport sink (
		input valid, found, near_a_x, near_a_y, near_a_z, near_b_x, near_b_y, near_b_z,
		output ready
	);
endinterface

// ===== sv/llcp_cfg_if.sv =====
// ----------------------------------------------------------------------------
// llcp_cfg_if
// Configuration write channel for the epsilon register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface llcp_cfg_if import llcp_pkg::*; ();
	logic valid;
	logic ready;
	logic [EPS_BITS-1:0] epsilon;

	modport source (output valid, epsilon, input ready);
	modport sink (input valid, epsilon, output ready);
endinterface

// ===== sv/llcp_dot.sv =====
// ----------------------------------------------------------------------------
// llcp_dot
// Five 3-term dot products of the difference vectors, two register stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module llcp_dot import llcp_pkg::*; #(
	parameter int DW = COORD_BITS_DEF + 1
) (
	input  logic                      clk,
	input  logic                      en,
	input  logic signed [DW-1:0]      u [3],
	input  logic signed [DW-1:0]      v [3],
	input  logic signed [DW-1:0]      w [3],
	output logic signed [2*DW:0]      dot [DOT_N]
);
	localparam int PW = 2 * DW;
	localparam int DOTW = 2 * DW + 1;

	logic signed [DW-1:0] opa [DOT_N][3];
	logic signed [DW-1:0] opb [DOT_N][3];
	logic signed [PW-1:0] prod [DOT_N][3];
	logic signed [PW-1:0] prod_s1 [DOT_N][3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			opa[DOT_WV][k] = w[k];
			opb[DOT_WV][k] = v[k];
			opa[DOT_VU][k] = v[k];
			opb[DOT_VU][k] = u[k];
			opa[DOT_WU][k] = w[k];
			opb[DOT_WU][k] = u[k];
			opa[DOT_VV][k] = v[k];
			opb[DOT_VV][k] = v[k];
			opa[DOT_UU][k] = u[k];
			opb[DOT_UU][k] = u[k];
		end
		for (int j = 0; j < DOT_N; j++) begin
			for (int k = 0; k < 3; k++) begin
				prod[j][k] = opa[j][k] * opb[j][k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= prod;
			for (int j = 0; j < DOT_N; j++) begin
				dot[j] <= DOTW'(prod_s1[j][0]) + DOTW'(prod_s1[j][1])
					+ DOTW'(prod_s1[j][2]);
			end
		end
	end
endmodule

// ===== sv/llcp_mul.sv =====
// ----------------------------------------------------------------------------
// llcp_mul
// Pipelined signed multiplier built from 32x32 partial products.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module llcp_mul import llcp_pkg::*; #(
	parameter int WA = 67,
	parameter int WB = 67
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [WA-1:0]    a,
	input  logic signed [WB-1:0]    b,
	output logic signed [WA+WB-1:0] p
);
	localparam int CW = MUL_CHUNK;
	localparam int NA = (WA + CW - 1) / CW;
	localparam int NB = (WB + CW - 1) / CW;
	localparam int PW = WA + WB;
	localparam int SW = (NA + NB) * CW;

	logic [WA-1:0]      abs_a;
	logic [WB-1:0]      abs_b;
	logic [NA*CW-1:0]   ma_s1;
	logic [NB*CW-1:0]   mb_s1;
	logic               neg_s1, neg_s2, neg_s3, neg_s4;
	logic [2*CW-1:0]    pp_s2 [NA][NB];
	logic [SW-1:0]      row [NA];
	logic [SW-1:0]      row_s3 [NA];
	logic [SW-1:0]      tot;
	logic [SW-1:0]      tot_s4;
	logic [SW-1:0]      tot_neg;

	// Sign and magnitude: the most negative input has a magnitude that
	// still fits the unsigned width.
	assign abs_a = a[WA-1] ? WA'(-a) : WA'(a);
	assign abs_b = b[WB-1] ? WB'(-b) : WB'(b);

	always_comb begin
		for (int i = 0; i < NA; i++) begin
			row[i] = '0;
			for (int j = 0; j < NB; j++) begin
				row[i] = row[i] + (SW'(pp_s2[i][j]) << (CW * j));
			end
		end
		tot = '0;
		for (int i = 0; i < NA; i++) begin
			tot = tot + (row_s3[i] << (CW * i));
		end
	end

	assign tot_neg = ~tot_s4 + SW'(1);

	always_ff @(posedge clk) begin
		if (en) begin
			ma_s1  <= (NA * CW)'(abs_a);
			mb_s1  <= (NB * CW)'(abs_b);
			neg_s1 <= a[WA-1] ^ b[WB-1];
			for (int i = 0; i < NA; i++) begin
				for (int j = 0; j < NB; j++) begin
					pp_s2[i][j] <= ma_s1[i*CW +: CW] * mb_s1[j*CW +: CW];
				end
			end
			neg_s2 <= neg_s1;
			row_s3 <= row;
			neg_s3 <= neg_s2;
			tot_s4 <= tot;
			neg_s4 <= neg_s3;
			p      <= neg_s4 ? tot_neg[PW-1:0] : tot_s4[PW-1:0];
		end
	end
endmodule

// ===== sv/llcp_div.sv =====
// ----------------------------------------------------------------------------
// llcp_div
// Pipelined rounded division, one quotient bit per stage, with offset and
// saturation of the result to the coordinate range.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module llcp_div import llcp_pkg::*; #(
	parameter int NW = 168,
	parameter int MW = 135,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         en,
	input  logic signed [NW-1:0]         num,
	input  logic signed [MW-1:0]         den,
	input  logic signed [COORD_BITS-1:0] base,
	output logic signed [COORD_BITS-1:0] res
);
	// Quotients of QB bits or more push any coordinate out of range, so only
	// QB bits are developed and a single compare flags the rest.
	localparam int QB = COORD_BITS + 2;
	localparam int RW = (NW + 2 > MW + 1 + QB) ? NW + 2 : MW + 1 + QB;
	localparam int SW = QB + 2;
	localparam logic [COORD_BITS-1:0] CMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
	localparam logic [COORD_BITS-1:0] CMIN = {1'b1, {(COORD_BITS-1){1'b0}}};

	logic [NW-1:0]                an_s1;
	logic [MW-1:0]                ad_s1;
	logic                         neg_s1;
	logic signed [COORD_BITS-1:0] base_s1;

	logic [RW-1:0]                rem_st [QB];
	logic [RW-1:0]                dd_st [QB];
	logic [QB-1:0]                q_st [1:QB];
	logic                         ovf_st [1:QB];
	logic                         neg_st [QB+1];
	logic signed [COORD_BITS-1:0] base_st [QB+1];

	logic [RW-1:0]                sh [QB];
	logic [RW:0]                  diff [QB];
	logic                         ge [QB];
	logic [RW-1:0]                nxt [QB-1];
	logic                         ovf_c;
	logic signed [QB:0]           sq;
	logic signed [SW-1:0]         sum;
	logic                         in_rng;
	logic [COORD_BITS-1:0]        res_c;

	always_comb begin
		for (int k = 0; k < QB; k++) begin
			sh[k]   = dd_st[k] << (QB - 1 - k);
			diff[k] = {1'b0, rem_st[k]} - {1'b0, sh[k]};
			ge[k]   = !diff[k][RW];
		end
		for (int k = 0; k < QB - 1; k++) begin
			nxt[k] = ge[k] ? diff[k][RW-1:0] : rem_st[k];
		end
		ovf_c = rem_st[0] >= (dd_st[0] << QB);
	end

	// Signed quotient, offset by the line's start point, then clamped.
	always_comb begin
		sq = neg_st[QB] ? -$signed({1'b0, q_st[QB]}) : $signed({1'b0, q_st[QB]});
		sum = SW'(base_st[QB]) + SW'(sq);
		in_rng = (sum[SW-1:COORD_BITS-1] == '0) || (sum[SW-1:COORD_BITS-1] == '1);
		if (ovf_st[QB]) begin
			res_c = neg_st[QB] ? CMIN : CMAX;
		end else if (in_rng) begin
			res_c = sum[COORD_BITS-1:0];
		end else begin
			res_c = sum[SW-1] ? CMIN : CMAX;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			an_s1   <= num[NW-1] ? NW'(-num) : NW'(num);
			ad_s1   <= den[MW-1] ? MW'(-den) : MW'(den);
			neg_s1  <= num[NW-1] ^ den[MW-1];
			base_s1 <= base;

			// Round to nearest, ties away from zero: (2|n| + |d|) / (2|d|).
			rem_st[0]  <= RW'({an_s1, 1'b0}) + RW'(ad_s1);
			dd_st[0]   <= RW'({ad_s1, 1'b0});
			neg_st[0]  <= neg_s1;
			base_st[0] <= base_s1;

			for (int k = 0; k < QB - 1; k++) begin
				rem_st[k+1] <= nxt[k];
				dd_st[k+1]  <= dd_st[k];
			end
			q_st[1]   <= {ge[0], {(QB-1){1'b0}}};
			ovf_st[1] <= ovf_c;
			for (int k = 1; k < QB; k++) begin
				q_st[k+1]   <= q_st[k] | (QB'(ge[k]) << (QB - 1 - k));
				ovf_st[k+1] <= ovf_st[k];
			end
			for (int k = 0; k < QB; k++) begin
				neg_st[k+1]  <= neg_st[k];
				base_st[k+1] <= base_st[k];
			end
			res <= res_c;
		end
	end
endmodule

// ===== sv/line_line_closest_points.sv =====
// ----------------------------------------------------------------------------
// line_line_closest_points
// Closest points between two 3D lines, each given by two Q16.16 points. The
// block is a rigid pipeline that takes one line pair per clock. Most of the
// pipeline is the divider, which develops one quotient bit per stage for
// each of the six output coordinates. While a result sits unread at the
// output the whole pipeline holds, and input ready drops with it. found is
// low and all coordinates are zero when a direction is shorter than epsilon
// in every component or when the denominator, taken as Q16.16, is zero or
// below epsilon. Epsilon is to be written through the configuration channel
// only while the block idles; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "line_line_closest_points_macros.svh"

module line_line_closest_points import llcp_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	llcp_in_if.sink    req,
	llcp_out_if.source rsp,
	llcp_cfg_if.sink   cfg
);
	localparam int DW = COORD_BITS + 1;
	localparam int DOTW = 2 * DW + 1;
	localparam int MW = 2 * DOTW + 1;
	localparam int NW = MW + DW;
	localparam int DIV_LAT = COORD_BITS + 5;
	localparam int S_M1 = 3 + MUL_LAT;
	localparam int S_MIX = S_M1 + 1;
	localparam int S_M2 = S_MIX + MUL_LAT;
	localparam int S_DIV = S_M2 + DIV_LAT;
	localparam int LAT = S_DIV + 1;
	localparam int M1A [6] = '{DOT_UU, DOT_VU, DOT_WV, DOT_WU, DOT_WV, DOT_VU};
	localparam int M1B [6] = '{DOT_VV, DOT_VU, DOT_VU, DOT_VV, DOT_UU, DOT_WU};

	logic [EPS_BITS-1:0]          eps_q;
	logic [LAT:1]                 vld;
	logic                         adv;

	logic signed [COORD_BITS-1:0] as_c [3];
	logic signed [COORD_BITS-1:0] ae_c [3];
	logic signed [COORD_BITS-1:0] bs_c [3];
	logic signed [COORD_BITS-1:0] be_c [3];

	logic signed [DW-1:0]         u_s1 [3];
	logic signed [DW-1:0]         v_s1 [3];
	logic signed [DW-1:0]         w_s1 [3];
	logic signed [COORD_BITS-1:0] base_p [1:S_M2][6];
	logic signed [DW-1:0]         uv_p [2:S_MIX][6];
	logic                         deg_p [2:S_MIX];
	logic signed [DOTW-1:0]       dot_s3 [DOT_N];
	logic signed [2*DOTW-1:0]     p1 [6];
	logic signed [MW-1:0]         den_s9;
	logic signed [MW-1:0]         na_s9;
	logic signed [MW-1:0]         nb_s9;
	logic [MW-1:0]                den_abs;
	logic                         bad;
	logic signed [MW-1:0]         den_p [S_MIX+1:S_M2];
	logic                         fail_p [S_MIX+1:S_DIV];
	logic signed [NW-1:0]         p2 [6];
	logic signed [COORD_BITS-1:0] q_div [6];
	logic                         found_q;
	logic signed [COORD_BITS-1:0] near_q [6];
	logic                         near_zero;

	// True when every component magnitude is below the threshold.
	function automatic logic small3(input logic signed [DW-1:0] x0,
			input logic signed [DW-1:0] x1, input logic signed [DW-1:0] x2,
			input logic [EPS_BITS-1:0] e);
		logic [DW-1:0] m0, m1, m2;
		m0 = x0[DW-1] ? DW'(-x0) : DW'(x0);
		m1 = x1[DW-1] ? DW'(-x1) : DW'(x1);
		m2 = x2[DW-1] ? DW'(-x2) : DW'(x2);
		return (m0 < DW'(e)) && (m1 < DW'(e)) && (m2 < DW'(e));
	endfunction

	assign as_c[0] = req.a_start_x;
	assign as_c[1] = req.a_start_y;
	assign as_c[2] = req.a_start_z;
	assign ae_c[0] = req.a_end_x;
	assign ae_c[1] = req.a_end_y;
	assign ae_c[2] = req.a_end_z;
	assign bs_c[0] = req.b_start_x;
	assign bs_c[1] = req.b_start_y;
	assign bs_c[2] = req.b_start_z;
	assign be_c[0] = req.b_end_x;
	assign be_c[1] = req.b_end_y;
	assign be_c[2] = req.b_end_z;

	assign adv = !vld[LAT] || rsp.ready;
	assign req.ready = adv;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= EPS_RESET;
			vld   <= '0;
		end else begin
			if (cfg.valid) begin
				eps_q <= cfg.epsilon;
			end
			if (adv) begin
				vld <= {vld[LAT-1:1], req.valid};
			end
		end
	end

	// Front end: difference vectors and the carried start points.
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				u_s1[k] <= DW'(ae_c[k]) - DW'(as_c[k]);
				v_s1[k] <= DW'(be_c[k]) - DW'(bs_c[k]);
				w_s1[k] <= DW'(as_c[k]) - DW'(bs_c[k]);
				base_p[1][k]     <= as_c[k];
				base_p[1][3 + k] <= bs_c[k];
				uv_p[2][k]     <= u_s1[k];
				uv_p[2][3 + k] <= v_s1[k];
			end
			for (int s = 2; s <= S_M2; s++) begin
				base_p[s] <= base_p[s-1];
			end
			for (int s = 3; s <= S_MIX; s++) begin
				uv_p[s]  <= uv_p[s-1];
				deg_p[s] <= deg_p[s-1];
			end
			deg_p[2] <= small3(u_s1[0], u_s1[1], u_s1[2], eps_q)
				|| small3(v_s1[0], v_s1[1], v_s1[2], eps_q);
		end
	end

	llcp_dot #(.DW(DW)) u_dot (
		.clk (clk),
		.en  (adv),
		.u   (u_s1),
		.v   (v_s1),
		.w   (w_s1),
		.dot (dot_s3)
	);

	for (genvar g = 0; g < 6; g++) begin : g_m1
		llcp_mul #(.WA(DOTW), .WB(DOTW)) u_mul (
			.clk (clk),
			.en  (adv),
			.a   (dot_s3[M1A[g]]),
			.b   (dot_s3[M1B[g]]),
			.p   (p1[g])
		);
	end

	// Denominator, the two numerators, and the near-parallel test.
	assign den_abs = den_s9[MW-1] ? MW'(-den_s9) : MW'(den_s9);
	assign bad = (den_s9 == '0) || (den_abs < MW'({eps_q, {EPS_SHIFT{1'b0}}}));

	always_ff @(posedge clk) begin
		if (adv) begin
			den_s9 <= MW'(p1[0]) - MW'(p1[1]);
			na_s9  <= MW'(p1[2]) - MW'(p1[3]);
			nb_s9  <= MW'(p1[4]) - MW'(p1[5]);
			den_p[S_MIX+1]  <= den_s9;
			fail_p[S_MIX+1] <= deg_p[S_MIX] || bad;
			for (int s = S_MIX + 2; s <= S_M2; s++) begin
				den_p[s] <= den_p[s-1];
			end
			for (int s = S_MIX + 2; s <= S_DIV; s++) begin
				fail_p[s] <= fail_p[s-1];
			end
		end
	end

	for (genvar g = 0; g < 6; g++) begin : g_m2
		if (g < 3) begin : g_a
			llcp_mul #(.WA(MW), .WB(DW)) u_mul (
				.clk (clk),
				.en  (adv),
				.a   (na_s9),
				.b   (uv_p[S_MIX][g]),
				.p   (p2[g])
			);
		end else begin : g_b
			llcp_mul #(.WA(MW), .WB(DW)) u_mul (
				.clk (clk),
				.en  (adv),
				.a   (nb_s9),
				.b   (uv_p[S_MIX][g]),
				.p   (p2[g])
			);
		end
		llcp_div #(.NW(NW), .MW(MW), .COORD_BITS(COORD_BITS)) u_div (
			.clk  (clk),
			.en   (adv),
			.num  (p2[g]),
			.den  (den_p[S_M2]),
			.base (base_p[S_M2][g]),
			.res  (q_div[g])
		);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			found_q <= !fail_p[S_DIV];
			for (int k = 0; k < 6; k++) begin
				near_q[k] <= fail_p[S_DIV] ? '0 : q_div[k];
			end
		end
	end

	assign rsp.valid    = vld[LAT];
	assign rsp.found    = found_q;
	assign rsp.near_a_x = near_q[0];
	assign rsp.near_a_y = near_q[1];
	assign rsp.near_a_z = near_q[2];
	assign rsp.near_b_x = near_q[3];
	assign rsp.near_b_y = near_q[4];
	assign rsp.near_b_z = near_q[5];

	assign near_zero = (near_q[0] == '0) && (near_q[1] == '0) && (near_q[2] == '0)
		&& (near_q[3] == '0) && (near_q[4] == '0) && (near_q[5] == '0);

	`LLCP_ASSERT_IMPL(a_nofound_zero, rsp.valid && !rsp.found, near_zero)
	`LLCP_ASSERT_NEXT(a_bubble_moves, adv && !vld[LAT-1], !rsp.valid)
	`LLCP_ASSERT_NEXT(a_fail_to_found, adv && vld[LAT-1] && fail_p[S_DIV], rsp.valid && !rsp.found)
endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the line-line closest points pipeline. Line pairs
// are sent through the request channel under varied sender and receiver
// idling. Each accepted pair is run through a wide-integer model of the
// closest point solution, and every result is compared field by field with
// the oldest pending prediction. Epsilon is swept over several values between
// traffic phases, always while the pipeline is empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
	import llcp_pkg::*;

	localparam int CB = COORD_BITS_DEF;
	localparam int PIPE_DEPTH = 2 * MUL_LAT + CB + 10;
	localparam int STALL_LIMIT = 5000;
	localparam logic signed [255:0] SAT_HI = (256'sd1 <<< (CB - 1)) - 256'sd1;
	localparam logic signed [255:0] SAT_LO = -(256'sd1 <<< (CB - 1));

	typedef logic signed [255:0] wide_t;

	typedef struct {
		logic signed [CB-1:0] c [12];
	} line_pair_t;

	typedef struct {
		logic found;
		logic signed [CB-1:0] p [6];
	} near_points_t;

	typedef enum int {
		PAIR_FULL,
		PAIR_MODEST,
		PAIR_PARALLEL,
		PAIR_SHORT_DIR,
		PAIR_EXTREME
	} pair_kind_e;

	logic clk;
	logic arst_n;

	llcp_in_if  #(.COORD_BITS(CB)) req ();
	llcp_out_if #(.COORD_BITS(CB)) rsp ();
	llcp_cfg_if cfg ();

	line_line_closest_points #(.COORD_BITS(CB)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp),
		.cfg(cfg)
	);

	near_points_t pending_points [$];
	logic [EPS_BITS-1:0] eps_model;
	int send_idle_pct;
	int recv_idle_pct;
	int hold_off_cycles;
	int mismatch_count;
	int checked_count;
	int found_count;
	int sent_count;
	int quiet_cycles;

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	function automatic wide_t abs_w(wide_t x);
		return (x < 0) ? -x : x;
	endfunction

	function automatic wide_t round_div(wide_t n, wide_t d);
		wide_t q;
		q = (2 * abs_w(n) + abs_w(d)) / (2 * abs_w(d));
		return ((n < 0) != (d < 0)) ? -q : q;
	endfunction

	function automatic logic signed [CB-1:0] saturate(wide_t x);
		if (x > SAT_HI)
			return SAT_HI[CB-1:0];
		if (x < SAT_LO)
			return SAT_LO[CB-1:0];
		return x[CB-1:0];
	endfunction

	function automatic near_points_t closest_points(line_pair_t lp, logic [EPS_BITS-1:0] eps);
		near_points_t r;
		wide_t c [12];
		wide_t u [3];
		wide_t v [3];
		wide_t w [3];
		wide_t eps_w, duu, dvv, dvu, dwu, dwv, den, na, nb;
		logic u_short, v_short;
		r.found = 1'b0;
		for (int k = 0; k < 6; k++)
			r.p[k] = '0;
		for (int k = 0; k < 12; k++)
			c[k] = lp.c[k];
		eps_w = {240'b0, eps};
		u_short = 1'b1;
		v_short = 1'b1;
		duu = 0; dvv = 0; dvu = 0; dwu = 0; dwv = 0;
		for (int k = 0; k < 3; k++) begin
			u[k] = c[3+k] - c[k];
			v[k] = c[9+k] - c[6+k];
			w[k] = c[k] - c[6+k];
			if (!(abs_w(u[k]) < eps_w))
				u_short = 1'b0;
			if (!(abs_w(v[k]) < eps_w))
				v_short = 1'b0;
			duu += u[k] * u[k];
			dvv += v[k] * v[k];
			dvu += v[k] * u[k];
			dwu += w[k] * u[k];
			dwv += w[k] * v[k];
		end
		if (u_short || v_short)
			return r;
		den = duu * dvv - dvu * dvu;
		if (den == 0 || abs_w(den) < (eps_w <<< EPS_SHIFT))
			return r;
		na = dwv * dvu - dwu * dvv;
		nb = dwv * duu - dvu * dwu;
		r.found = 1'b1;
		for (int k = 0; k < 3; k++) begin
			r.p[k] = saturate(c[k] + round_div(na * u[k], den));
			r.p[3+k] = saturate(c[6+k] + round_div(nb * v[k], den));
		end
		return r;
	endfunction

	// Predictions are made at the edge where a pair is accepted, with the
	// epsilon in force at that moment; results are checked in order.
	always @(posedge clk) begin
		near_points_t exp_pts;
		near_points_t got;
		logic bad;
		line_pair_t lp;
		if (arst_n) begin
			if (cfg.valid && cfg.ready)
				eps_model <= cfg.epsilon;
			if (req.valid && req.ready) begin
				lp.c = '{req.a_start_x, req.a_start_y, req.a_start_z,
					req.a_end_x, req.a_end_y, req.a_end_z,
					req.b_start_x, req.b_start_y, req.b_start_z,
					req.b_end_x, req.b_end_y, req.b_end_z};
				pending_points.push_back(closest_points(lp, eps_model));
			end
			if (rsp.valid && rsp.ready) begin
				got.found = rsp.found;
				got.p = '{rsp.near_a_x, rsp.near_a_y, rsp.near_a_z,
					rsp.near_b_x, rsp.near_b_y, rsp.near_b_z};
				if (pending_points.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("ERROR: unexpected result at %0t", $realtime);
				end else begin
					exp_pts = pending_points.pop_front();
					bad = (got.found !== exp_pts.found);
					for (int k = 0; k < 6; k++)
						if (got.p[k] !== exp_pts.p[k])
							bad = 1'b1;
					if (bad) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("ERROR: result %0d exp found=%0b %p got found=%0b %p",
								checked_count, exp_pts.found, exp_pts.p, got.found, got.p);
					end
					if (exp_pts.found)
						found_count++;
					checked_count++;
				end
			end
		end
	end

	// Receiver: random stalls, or a long counted hold-off when one is requested.
	always @(negedge clk) begin
		if (hold_off_cycles > 0) begin
			rsp.ready <= 1'b0;
			hold_off_cycles <= hold_off_cycles - 1;
		end else begin
			rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready)
				|| !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Called at a falling edge; returns at a falling edge after acceptance.
	task automatic send_pair(line_pair_t lp);
		while ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(negedge clk);
		end
		req.valid <= 1'b1;
		{req.a_start_x, req.a_start_y, req.a_start_z} <= {lp.c[0], lp.c[1], lp.c[2]};
		{req.a_end_x, req.a_end_y, req.a_end_z} <= {lp.c[3], lp.c[4], lp.c[5]};
		{req.b_start_x, req.b_start_y, req.b_start_z} <= {lp.c[6], lp.c[7], lp.c[8]};
		{req.b_end_x, req.b_end_y, req.b_end_z} <= {lp.c[9], lp.c[10], lp.c[11]};
		do
			@(posedge clk);
		while (!req.ready);
		sent_count++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		req.valid <= 1'b0;
		while (pending_points.size() != 0)
			@(negedge clk);
		repeat (PIPE_DEPTH + 8) @(negedge clk);
	endtask

	task automatic write_epsilon(logic [EPS_BITS-1:0] eps);
		wait_drained();
		cfg.valid <= 1'b1;
		cfg.epsilon <= eps;
		do
			@(posedge clk);
		while (!cfg.ready);
		@(negedge clk);
		cfg.valid <= 1'b0;
		@(negedge clk);
	endtask

	function automatic line_pair_t make_pair(logic signed [CB-1:0] v [12]);
		line_pair_t lp;
		lp.c = v;
		return lp;
	endfunction

	function automatic logic signed [CB-1:0] rand_coord(int span_bits);
		logic signed [CB-1:0] x;
		x = $urandom;
		return x >>> (CB - span_bits);
	endfunction

	function automatic line_pair_t random_pair();
		line_pair_t lp;
		pair_kind_e kind;
		int span;
		int pick;
		pick = $urandom_range(99);
		kind = (pick < 15) ? PAIR_FULL : (pick < 60) ? PAIR_MODEST :
			(pick < 80) ? PAIR_PARALLEL : (pick < 90) ? PAIR_SHORT_DIR : PAIR_EXTREME;
		span = $urandom_range(CB, 8);
		for (int k = 0; k < 12; k++)
			lp.c[k] = (kind == PAIR_FULL) ? $urandom : rand_coord(span);
		case (kind)
			PAIR_PARALLEL: begin
				// Direction of B is a multiple of A's plus a few units of skew.
				for (int k = 0; k < 3; k++) begin
					lp.c[3+k] = lp.c[k] + rand_coord(20);
					lp.c[9+k] = lp.c[6+k] + (lp.c[3+k] - lp.c[k]) * $signed($urandom_range(3, 1))
						+ $signed($urandom_range(6)) - 3;
				end
			end
			PAIR_SHORT_DIR: begin
				for (int k = 0; k < 3; k++) begin
					if ($urandom_range(1))
						lp.c[3+k] = lp.c[k] + $signed($urandom_range(4)) - 2;
					else
						lp.c[9+k] = lp.c[6+k] + $signed($urandom_range(70000)) - 35000;
				end
			end
			PAIR_EXTREME: begin
				for (int k = 0; k < 12; k++)
					if ($urandom_range(1))
						lp.c[k] = $urandom_range(1) ? SAT_HI[CB-1:0] : SAT_LO[CB-1:0];
			end
			default: ;
		endcase
		return lp;
	endfunction

	task automatic test_directed();
		logic signed [CB-1:0] one, mx, mn;
		one = 32'sh0001_0000;
		mx = SAT_HI[CB-1:0];
		mn = SAT_LO[CB-1:0];
		// All points at the origin: both directions vanish.
		send_pair(make_pair('{default: '0}));
		// Crossing axes, then skew lines a unit apart.
		send_pair(make_pair('{0, 0, 0, one, 0, 0, 0, 0, 0, 0, one, 0}));
		send_pair(make_pair('{0, 0, 0, one, 0, 0, 0, 0, one, 0, one, one}));
		// Exactly parallel lines give a zero denominator.
		send_pair(make_pair('{0, 0, 0, one, one, 0, 0, one, 0, 2*one, 3*one, 0}));
		// Almost parallel: a one-unit skew.
		send_pair(make_pair('{0, 0, 0, one, 0, 0, 0, one, 0, one, one, 1}));
		// Only line A is degenerate, then only line B.
		send_pair(make_pair('{5, 5, 5, 5, 5, 5, 0, 0, 0, 0, one, 0}));
		send_pair(make_pair('{0, 0, 0, one, 0, 0, 7, 7, 7, 7, 7, 7}));
		// Full-scale coordinates, with one small-valued pair among them.
		send_pair(make_pair('{mn, mn, mn, mx, mx, mx, mx, mn, 0, mn, mx, 0}));
		send_pair(make_pair('{mx, 0, 0, mn, 1, 0, 0, mx, 0, 1, mn, 3}));
		send_pair(make_pair('{mn, mx, mn, mx, mn, mx, mx, mx, mn, mn, mn, mx}));
		send_pair(make_pair('{-1, -1, -1, 1, 0, -1, 0, 1, 1, -1, 1, 0}));
		send_pair(make_pair('{mx, mx, mx, mx, mx, mx, mn, mn, mn, mn, mn, mn}));
		// Directions close to epsilon in every component.
		send_pair(make_pair('{0, 0, 0, 1, 1, 1, 0, 0, 0, -1, 2, 0}));
		send_pair(make_pair('{0, 0, 0, 1, -1, 0, 10, 10, 10, 10, 11, 9}));
	endtask

	task automatic test_random_phase(int n, int send_pct, int recv_pct);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		for (int i = 0; i < n; i++) begin
			// Now and then let a burst run with no sender idling.
			if (i % 64 == 32)
				send_idle_pct = 0;
			else if (i % 64 == 48)
				send_idle_pct = send_pct;
			send_pair(random_pair());
		end
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_off_cycles = 300;
		for (int i = 0; i < 90; i++)
			send_pair(random_pair());
	endtask

	task automatic test_send_pause();
		for (int i = 0; i < 20; i++)
			send_pair(random_pair());
		wait_drained();
		for (int i = 0; i < 20; i++)
			send_pair(random_pair());
	endtask

	task automatic test_epsilon_sweep();
		logic [EPS_BITS-1:0] settings [4];
		settings = '{16'd0, 16'hFFFF, 16'd64, 16'($urandom)};
		foreach (settings[i]) begin
			write_epsilon(settings[i]);
			test_directed();
			test_random_phase(25, 10, 10);
		end
	endtask

	initial begin
		req.valid = 1'b0;
		{req.a_start_x, req.a_start_y, req.a_start_z} = '0;
		{req.a_end_x, req.a_end_y, req.a_end_z} = '0;
		{req.b_start_x, req.b_start_y, req.b_start_z} = '0;
		{req.b_end_x, req.b_end_y, req.b_end_z} = '0;
		cfg.valid = 1'b0;
		cfg.epsilon = '0;
		rsp.ready = 1'b0;
		eps_model = EPS_RESET;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_off_cycles = 0;
		mismatch_count = 0;
		checked_count = 0;
		found_count = 0;
		sent_count = 0;
		quiet_cycles = 0;
		arst_n = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		write_epsilon(16'd1);
		test_random_phase(250, 32, 75);
		test_random_phase(250, 75, 32);
		test_random_phase(250, 0, 0);
		test_backpressure();
		test_send_pause();
		test_epsilon_sweep();
		wait_drained();

		$display("Sent %0d line pairs, checked %0d results, %0d with a solution.",
			sent_count, checked_count, found_count);
		$display("Covered five epsilon settings, long output stalls and idle gaps on both sides.");
		if (mismatch_count == 0 && pending_points.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
